// ===== src/qlsse_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qlsse_pkg
// Types, constants and helpers shared by the quadrant sun sensor error block.
// ----------------------------------------------------------------------------
package qlsse_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int REG_BITS    = 12;
  localparam int CHANNELS    = 4;
  localparam int ERR_BITS    = 15;
  localparam int AVG_BITS    = 12;
  localparam int COUNT_BITS  = 16;

  // Channel order within a round.
  localparam int CH_TL = 0;
  localparam int CH_TR = 1;
  localparam int CH_BL = 2;
  localparam int CH_BR = 3;

  // Register indexes of the configuration port.
  localparam int CFG_ADDR_BITS = 2;
  localparam logic [CFG_ADDR_BITS-1:0] REG_MIN_LEVEL = 2'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_MAX_LEVEL = 2'd1;
  localparam logic [CFG_ADDR_BITS-1:0] REG_SUN_THR   = 2'd2;

  localparam logic [REG_BITS-1:0] MIN_LEVEL_RST = 12'd0;
  localparam logic [REG_BITS-1:0] MAX_LEVEL_RST = 12'd4095;
  localparam logic [REG_BITS-1:0] SUN_THR_RST   = 12'd200;

  // Stream widths.
  localparam int IN_DATA_BITS   = ((CHANNELS * SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_BITS = 2 + 2 * ERR_BITS + AVG_BITS + COUNT_BITS;
  localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

  // Datapath widths.
  localparam int CMP_BITS  = (SAMPLE_BITS > REG_BITS) ? SAMPLE_BITS : REG_BITS;
  localparam int SUM_BITS  = SAMPLE_BITS + 2;
  localparam int PAIR_BITS = SAMPLE_BITS + 1;
  localparam int MAG_BITS  = SAMPLE_BITS + 1;
  localparam int SCL_BITS  = MAG_BITS + 3;
  // floor(y / 5) = (y * DIV_MULT) >> DIV_SHIFT, exact for y below 2^22.
  localparam int DIV_SHIFT = 24;
  localparam int MULT_BITS = 22;
  localparam logic [MULT_BITS-1:0] DIV_MULT = MULT_BITS'(((1 << DIV_SHIFT) + 4) / 5);
  localparam int PROD_BITS = SCL_BITS + MULT_BITS;
  localparam int QUO_BITS  = SAMPLE_BITS + 2;
  localparam int ERRW      = (QUO_BITS + 1 > ERR_BITS) ? QUO_BITS + 1 : ERR_BITS;

  // Queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  typedef logic [SAMPLE_BITS-1:0] sample_t;

  typedef enum logic {
    OP_CLEAR = 1'b0,
    OP_EMIT  = 1'b1
  } op_e;

  typedef struct packed {
    op_e                    op;
    sample_t [CHANNELS-1:0] med;
  } job_t;

  typedef struct packed {
    logic                 full;
    logic                 empty;
    logic [QCNT_BITS-1:0] level;
  } q_status_t;

  typedef struct packed {
    logic [REG_BITS-1:0] min_level;
    logic [REG_BITS-1:0] max_level;
    logic [REG_BITS-1:0] sun_thr;
  } cfg_t;

  function automatic sample_t mid3(sample_t x, sample_t y, sample_t z);
    sample_t m;
    if (x > y) begin
      if (y > z) m = y;
      else       m = (x > z) ? z : x;
    end else begin
      if (x > z) m = x;
      else       m = (y > z) ? z : y;
    end
    return m;
  endfunction

endpackage
`default_nettype wire

// ===== src/qlsse_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qlsse_front
// Accept requests, hold two sample rounds and queue medians or counter clears.
// ----------------------------------------------------------------------------
module qlsse_front import qlsse_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    req_valid_i,
  input  wire logic                    req_kind_i,
  input  wire sample_t [CHANNELS-1:0]  req_smp_i,
  input  wire q_status_t               q_status_i,
  output logic                         req_ready_o,
  output logic                         push_o,
  output job_t                         push_job_o,
  output logic [1:0]                   round_o
);

  sample_t [CHANNELS-1:0] held_q [2];
  logic    [1:0]          round_q, round_d;
  logic                   accept;
  logic                   emit_round;

  assign req_ready_o = !q_status_i.full;
  assign accept      = req_valid_i && req_ready_o;
  assign emit_round  = round_q[1];

  always_comb begin
    round_d         = round_q;
    push_o          = 1'b0;
    push_job_o.op   = OP_CLEAR;
    for (int c = 0; c < CHANNELS; c++) begin
      push_job_o.med[c] = mid3(held_q[0][c], held_q[1][c], req_smp_i[c]);
    end
    if (accept) begin
      if (req_kind_i) begin
        push_o = 1'b1;
      end else if (emit_round) begin
        push_o        = 1'b1;
        push_job_o.op = OP_EMIT;
        round_d       = 2'd0;
      end else begin
        round_d = round_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      round_q <= 2'd0;
    end else begin
      round_q <= round_d;
    end
  end

  // Hold the first two rounds of each triple.
  always_ff @(posedge clk_i) begin
    if (accept && !req_kind_i && !emit_round) begin
      held_q[round_q[0]] <= req_smp_i;
    end
  end

  assign round_o = round_q;

endmodule
`default_nettype wire

// ===== src/qlsse_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qlsse_queue
// Short queue of jobs between the front and the back.
// ----------------------------------------------------------------------------
module qlsse_queue import qlsse_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire job_t      push_job_i,
  input  wire logic      pop_i,
  output job_t           head_o,
  output q_status_t      status_o
);

  job_t                 mem_q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_BITS-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_BITS-1:0] count_q, count_d;
  logic                 do_push, do_pop;

  assign status_o.full  = (count_q == QCNT_BITS'(QUEUE_DEPTH));
  assign status_o.empty = (count_q == '0);
  assign status_o.level = count_q;

  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_BITS'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_BITS'(1);
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + QCNT_BITS'(1);
      2'b01:   count_d = count_q - QCNT_BITS'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  assign head_o = mem_q[rd_ptr_q];

endmodule
`default_nettype wire

// ===== src/qlsse_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qlsse_back
// Check limits, average, count faults and scale the pointing errors.
// ----------------------------------------------------------------------------
module qlsse_back import qlsse_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire cfg_t                     cfg_i,
  input  wire job_t                     head_i,
  input  wire q_status_t                q_status_i,
  output logic                          pop_o,
  output logic                          res_valid_o,
  input  wire logic                     res_ready_i,
  output logic [OUT_DATA_BITS-1:0]      res_data_o
);

  // Check stage.
  logic                  a_vld_q;
  logic                  a_ok_q, a_ok_d;
  logic                  a_sun_q, a_sun_d;
  logic [SAMPLE_BITS-1:0] a_avg_q, a_avg_d;
  logic                  a_az_neg_q, a_az_neg_d, a_el_neg_q, a_el_neg_d;
  logic [SCL_BITS-1:0]   a_az_scl_q, a_az_scl_d, a_el_scl_q, a_el_scl_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;

  // Output register.
  logic                  b_vld_q;
  logic                  b_ok_q, b_sun_q;
  logic [ERR_BITS-1:0]   b_az_q, b_az_d, b_el_q, b_el_d;
  logic [AVG_BITS-1:0]   b_avg_q;
  logic [COUNT_BITS-1:0] b_cnt_q;

  logic                  b_free, a_take, a_free;
  logic [2:0]            n_faults;
  logic [SUM_BITS-1:0]   sum;
  logic [PAIR_BITS-1:0]  p_right, p_left, p_top, p_bot;
  logic [SUM_BITS-1:0]   d_az, d_el;
  logic [MAG_BITS-1:0]   m_az, m_el;
  logic [CMP_BITS-1:0]   med_x, min_x, max_x;
  logic [PROD_BITS-1:0]  prod_az, prod_el;
  logic [ERRW-1:0]       q_az, q_el;
  logic [COUNT_BITS-1:0] a_cnt_q;

  assign b_free = !b_vld_q || res_ready_i;
  assign a_free = !a_vld_q || b_free;
  assign pop_o  = a_free && !q_status_i.empty;
  assign a_take = pop_o && (head_i.op == OP_EMIT);

  always_comb begin
    n_faults = 3'd0;
    sum      = '0;
    min_x    = CMP_BITS'(cfg_i.min_level);
    max_x    = CMP_BITS'(cfg_i.max_level);
    for (int c = 0; c < CHANNELS; c++) begin
      med_x    = CMP_BITS'(head_i.med[c]);
      n_faults = n_faults + 3'((med_x < min_x) || (med_x > max_x));
      sum      = sum + SUM_BITS'(head_i.med[c]);
    end
    a_ok_d  = (n_faults < 3'd2);
    a_avg_d = sum[SUM_BITS-1:2];
    a_sun_d = CMP_BITS'(a_avg_d) > CMP_BITS'(cfg_i.sun_thr);

    p_right = PAIR_BITS'(head_i.med[CH_TR]) + PAIR_BITS'(head_i.med[CH_BR]);
    p_left  = PAIR_BITS'(head_i.med[CH_TL]) + PAIR_BITS'(head_i.med[CH_BL]);
    p_top   = PAIR_BITS'(head_i.med[CH_TL]) + PAIR_BITS'(head_i.med[CH_TR]);
    p_bot   = PAIR_BITS'(head_i.med[CH_BL]) + PAIR_BITS'(head_i.med[CH_BR]);
    d_az    = SUM_BITS'(p_right) - SUM_BITS'(p_left);
    d_el    = SUM_BITS'(p_top) - SUM_BITS'(p_bot);
    a_az_neg_d = d_az[SUM_BITS-1];
    a_el_neg_d = d_el[SUM_BITS-1];
    m_az    = a_az_neg_d ? MAG_BITS'(-d_az) : MAG_BITS'(d_az);
    m_el    = a_el_neg_d ? MAG_BITS'(-d_el) : MAG_BITS'(d_el);
    // Scale by 16/10 = 8/5; no sun drops the errors to zero.
    a_az_scl_d = a_sun_d ? {m_az, 3'b000} : '0;
    a_el_scl_d = a_sun_d ? {m_el, 3'b000} : '0;

    cnt_d = cnt_q;
    if (pop_o) begin
      if (head_i.op == OP_CLEAR) cnt_d = '0;
      else if (!a_ok_d)          cnt_d = cnt_q + COUNT_BITS'(1);
    end
  end

  // Divide by five through the reciprocal, then restore the sign.
  always_comb begin
    prod_az = PROD_BITS'(a_az_scl_q) * PROD_BITS'(DIV_MULT);
    prod_el = PROD_BITS'(a_el_scl_q) * PROD_BITS'(DIV_MULT);
    q_az    = ERRW'(prod_az[DIV_SHIFT +: QUO_BITS]);
    q_el    = ERRW'(prod_el[DIV_SHIFT +: QUO_BITS]);
    b_az_d  = a_az_neg_q ? ERR_BITS'(ERRW'(0) - q_az) : ERR_BITS'(q_az);
    b_el_d  = a_el_neg_q ? ERR_BITS'(ERRW'(0) - q_el) : ERR_BITS'(q_el);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (a_free) a_vld_q <= a_take;
      if (b_free) b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_take) begin
      a_ok_q     <= a_ok_d;
      a_sun_q    <= a_sun_d;
      a_avg_q    <= a_avg_d;
      a_az_neg_q <= a_az_neg_d;
      a_el_neg_q <= a_el_neg_d;
      a_az_scl_q <= a_az_scl_d;
      a_el_scl_q <= a_el_scl_d;
      a_cnt_q    <= cnt_d;
    end
    if (b_free && a_vld_q) begin
      b_ok_q  <= a_ok_q;
      b_sun_q <= a_sun_q;
      b_az_q  <= b_az_d;
      b_el_q  <= b_el_d;
      b_avg_q <= AVG_BITS'(a_avg_q);
      b_cnt_q <= a_cnt_q;
    end
  end

  assign res_valid_o = b_vld_q;
  assign res_data_o  = OUT_DATA_BITS'({b_cnt_q, b_avg_q, b_el_q, b_az_q, b_sun_q, b_ok_q});

endmodule
`default_nettype wire

// ===== src/quad_light_sensor_sun_error_top.sv =====
`default_nettype none
// Path: an emitting round passes the queue, the check stage and the output register before it shows on the master side.
// Throughput: one request per cycle while the queue is not full; only the first two
//   rounds of a triple and counter clears give no result, and the queue lets requests
//   in while a result waits.
// Reset: clears the round index, the error counter, the queue and all valid flags,
//   and loads the limit registers with their defaults; held rounds need no reset.
// ----------------------------------------------------------------------------
// quad_light_sensor_sun_error_top
// Quadrant photodiode sun sensor: median of three rounds, limit check, sun
// detection and scaled azimuth and elevation errors.
// ----------------------------------------------------------------------------
module quad_light_sensor_sun_error_top import qlsse_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  // Sample rounds and counter clears.
  input  wire logic                     s_axis_tvalid,
  output logic                          s_axis_tready,
  // tdata: top_left_sample, top_right_sample, bottom_left_sample,
  //        bottom_right_sample
  input  wire logic [IN_DATA_BITS-1:0]  s_axis_tdata,
  // tuser: kind
  input  wire logic                     s_axis_tuser,
  // Results.
  output logic                          m_axis_tvalid,
  input  wire logic                     m_axis_tready,
  // tdata: reading_valid, sun_present, horiz_error, vert_error,
  //        light_average, error_count, zero padding
  output logic [OUT_DATA_BITS-1:0]      m_axis_tdata,
  // Configuration writes.
  input  wire logic                     cfg_we_i,
  input  wire logic [CFG_ADDR_BITS-1:0] cfg_addr_i,
  input  wire logic [REG_BITS-1:0]      cfg_wdata_i
);

  cfg_t                   cfg_q;
  sample_t [CHANNELS-1:0] smp;
  logic                   push, pop;
  job_t                   push_job, head;
  q_status_t              q_status;
  logic [1:0]             round;

  // Limit and threshold registers; an unknown index is dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_level <= MIN_LEVEL_RST;
      cfg_q.max_level <= MAX_LEVEL_RST;
      cfg_q.sun_thr   <= SUN_THR_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_MIN_LEVEL: cfg_q.min_level <= cfg_wdata_i;
        REG_MAX_LEVEL: cfg_q.max_level <= cfg_wdata_i;
        REG_SUN_THR:   cfg_q.sun_thr   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Unpack the four channels from the lowest bits up.
  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      smp[c] = s_axis_tdata[c*SAMPLE_BITS +: SAMPLE_BITS];
    end
  end

  // Front: hold rounds, take medians on every third round, queue clears in order.
  qlsse_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_kind_i  (s_axis_tuser),
    .req_smp_i   (smp),
    .q_status_i  (q_status),
    .req_ready_o (s_axis_tready),
    .push_o      (push),
    .push_job_o  (push_job),
    .round_o     (round)
  );

  // Queue: lets the front keep taking requests while the back is stalled.
  qlsse_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .pop_i      (pop),
    .head_o     (head),
    .status_o   (q_status)
  );

  // Back: limit check and counter, then scaling into the output register.
  qlsse_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .head_i      (head),
    .q_status_i  (q_status),
    .pop_o       (pop),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_data_o  (m_axis_tdata)
  );

  // The front never pushes into a full queue.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_status.full)
    else $error("push into full queue");

  // Queue level stays within its depth.
  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_status.level <= QCNT_BITS'(QUEUE_DEPTH))
    else $error("queue level beyond depth");

  // The round index never reaches three.
  a_round_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    round != 2'd3)
    else $error("round index out of range");

  // Without sun both pointing errors are zero.
  a_no_sun_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[1]) |->
      (m_axis_tdata[2 +: ERR_BITS] == '0 && m_axis_tdata[2+ERR_BITS +: ERR_BITS] == '0))
    else $error("pointing error without sun");

endmodule
`default_nettype wire

// ===== sim/quad_light_sensor_sun_error_top_tb.sv =====
// ----------------------------------------------------------------------------
// quad_light_sensor_sun_error_top_tb
// Self-checking bench for the quadrant sun sensor error block. Sample rounds
// and counter clears go in on the slave stream. A predictor works out the
// median of three rounds, the limit check, sun detection and the scaled
// errors, and queues one expected reading for every third round. Each
// reading on the master stream is checked field by field against the
// oldest one queued. Both streams stall at random in the random traffic tests.
// ----------------------------------------------------------------------------
module quad_light_sensor_sun_error_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import qlsse_pkg::*;

  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int PRINT_LIMIT  = 30;
  localparam int RANDOM_ITEMS = 312;
  localparam int SETTLE_TICKS = 8;

  // Request kind as carried on tuser.
  typedef enum logic {
    KIND_ROUND = 1'b0,
    KIND_CLEAR = 1'b1
  } request_kind_e;

  // Master tdata fields, highest bit first (last member sits at bit 0).
  typedef struct packed {
    logic [COUNT_BITS-1:0]      error_count;
    logic [AVG_BITS-1:0]        light_average;
    logic signed [ERR_BITS-1:0] vert_error;
    logic signed [ERR_BITS-1:0] horiz_error;
    logic                       sun_present;
    logic                       reading_valid;
  } sun_reading_t;

  typedef sample_t [CHANNELS-1:0] round_t;

  // Block ports; every input starts at a known value.
  logic                     clk_i         = 1'b0;
  logic                     rst_ni        = 1'b0;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [IN_DATA_BITS-1:0]  s_axis_tdata  = '0;
  logic                     s_axis_tuser  = 1'b0;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] m_axis_tdata;
  logic                     cfg_we_i      = 1'b0;
  logic [CFG_ADDR_BITS-1:0] cfg_addr_i    = '0;
  logic [REG_BITS-1:0]      cfg_wdata_i   = '0;

  // Predictor state: two held rounds, the round index, the error counter
  // and the limit registers.
  round_t                held_rounds [2];
  int unsigned           rounds_held   = 0;
  logic [COUNT_BITS-1:0] invalid_count = '0;
  cfg_t                  limits        = '{MIN_LEVEL_RST, MAX_LEVEL_RST, SUN_THR_RST};

  sun_reading_t pending_readings [$];

  int          mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_idle_pct  = 0;

  quad_light_sensor_sun_error_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // Hard stop in case the block hangs.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("quad_light_sensor_sun_error_top regression: fail");
      $finish;
    end
  end

  // Receiver back-pressure: drop tready for the share of cycles asked.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Print one line per mismatch (up to a cap, so a broken run stays readable).
  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT)
      $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
  endtask

  function automatic sample_t median_of_three(sample_t a, sample_t b, sample_t c);
    sample_t lo;
    sample_t hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (c < lo) return lo;
    if (c > hi) return hi;
    return c;
  endfunction

  // Advance the predictor by one accepted request; queue a reading on the
  // third round of every triple.
  task automatic compute_sun_reading(input request_kind_e kind, input round_t smp);
    sample_t      med [CHANNELS];
    int unsigned  faults;
    int unsigned  total;
    int           diff_h;
    int           diff_v;
    sun_reading_t rd;
    faults = 0;
    total  = 0;
    rd     = '0;
    if (kind == KIND_CLEAR) begin
      // Counter only; held rounds and the round index stay.
      invalid_count = '0;
      return;
    end
    if (rounds_held < 2) begin
      held_rounds[rounds_held] = smp;
      rounds_held++;
      return;
    end
    rounds_held = 0;
    for (int c = 0; c < CHANNELS; c++) begin
      med[c] = median_of_three(held_rounds[0][c], held_rounds[1][c], smp[c]);
      if (med[c] < limits.min_level || med[c] > limits.max_level) faults++;
      total += med[c];
    end
    rd.reading_valid = (faults < 2);
    if (!rd.reading_valid) invalid_count++;
    rd.error_count   = invalid_count;
    rd.light_average = AVG_BITS'(total / 4);
    rd.sun_present   = (rd.light_average > limits.sun_thr);
    if (rd.sun_present) begin
      diff_h = (int'(med[CH_TR]) + int'(med[CH_BR])) - (int'(med[CH_TL]) + int'(med[CH_BL]));
      diff_v = (int'(med[CH_TL]) + int'(med[CH_TR])) - (int'(med[CH_BL]) + int'(med[CH_BR]));
      // Integer division truncates toward zero, as the s10.4 format needs.
      rd.horiz_error = ERR_BITS'((diff_h * 16) / 10);
      rd.vert_error  = ERR_BITS'((diff_v * 16) / 10);
    end
    pending_readings.push_back(rd);
  endtask

  // Check every reading taken off the master side against the oldest one queued.
  always @(posedge clk_i) begin
    sun_reading_t got;
    sun_reading_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = sun_reading_t'(m_axis_tdata[OUT_FIELD_BITS-1:0]);
      if (m_axis_tdata[OUT_DATA_BITS-1:OUT_FIELD_BITS] !== '0)
        report_mismatch("padding", m_axis_tdata[OUT_DATA_BITS-1:OUT_FIELD_BITS], 0);
      if (pending_readings.size() == 0) begin
        report_mismatch("unexpected reading", m_axis_tdata, 0);
      end else begin
        want = pending_readings.pop_front();
        if (got.reading_valid !== want.reading_valid)
          report_mismatch("reading_valid", got.reading_valid, want.reading_valid);
        if (got.sun_present !== want.sun_present)
          report_mismatch("sun_present", got.sun_present, want.sun_present);
        if (got.horiz_error !== want.horiz_error)
          report_mismatch("horiz_error", got.horiz_error, want.horiz_error);
        if (got.vert_error !== want.vert_error)
          report_mismatch("vert_error", got.vert_error, want.vert_error);
        if (got.light_average !== want.light_average)
          report_mismatch("light_average", got.light_average, want.light_average);
        if (got.error_count !== want.error_count)
          report_mismatch("error_count", got.error_count, want.error_count);
      end
    end
  end

  // Offer one request, with a random hold-off first, and wait for the handshake.
  // tvalid is only lowered when a gap is taken, so it never toggles within a step.
  task automatic send_request(input request_kind_e kind, input round_t smp);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= smp;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    compute_sun_reading(kind, smp);
  endtask

  task automatic send_round(input sample_t tl, input sample_t tr,
                            input sample_t bl, input sample_t br);
    round_t smp;
    smp[CH_TL] = tl;
    smp[CH_TR] = tr;
    smp[CH_BL] = bl;
    smp[CH_BR] = br;
    send_request(KIND_ROUND, smp);
  endtask

  // Random round: mostly clustered around one level so the errors stay small
  // and near the threshold, with rails and wild values mixed in.
  function automatic round_t random_round();
    round_t smp;
    int     base;
    int     lvl;
    base = $urandom_range(4095);
    for (int c = 0; c < CHANNELS; c++) begin
      case ($urandom_range(7))
        0:       lvl = 0;
        1:       lvl = 4095;
        2, 3:    lvl = $urandom_range(4095);
        default: lvl = base + $urandom_range(64) - 32;
      endcase
      if (lvl < 0)    lvl = 0;
      if (lvl > 4095) lvl = 4095;
      smp[c] = sample_t'(lvl);
    end
    return smp;
  endfunction

  // Hold until every reading has come out, then let the pipe settle.
  task automatic wait_until_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (SETTLE_TICKS) @(posedge clk_i);
  endtask

  // Write all three limit registers back to back while the block is idle.
  task automatic write_limits(input int min_lvl, input int max_lvl, input int thr);
    wait_until_idle();
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= REG_MIN_LEVEL;
    cfg_wdata_i <= REG_BITS'(min_lvl);
    @(posedge clk_i);
    cfg_addr_i  <= REG_MAX_LEVEL;
    cfg_wdata_i <= REG_BITS'(max_lvl);
    @(posedge clk_i);
    cfg_addr_i  <= REG_SUN_THR;
    cfg_wdata_i <= REG_BITS'(thr);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    limits.min_level = REG_BITS'(min_lvl);
    limits.max_level = REG_BITS'(max_lvl);
    limits.sun_thr   = REG_BITS'(thr);
  endtask

  // Reset limits: dark sky, full-scale errors both ways, median picking
  // from scrambled rounds.
  task automatic test_median_and_direction();
    repeat (3) send_round(0, 0, 0, 0);
    // Medians 0, 4095, 0, 4095: right side lit, largest positive azimuth.
    send_round(0, 4095, 4095, 4095);
    send_round(4095, 0, 0, 4095);
    send_round(0, 4095, 0, 0);
    // Medians 0, 0, 4095, 4095: bottom lit, largest negative elevation.
    send_round(0, 0, 4095, 4095);
    send_round(1, 3, 4090, 4094);
    send_round(0, 0, 4095, 4095);
  endtask

  // A one-count difference on both axes: -1.6 must give -1, not -2.
  task automatic test_truncation();
    repeat (3) send_round(300, 300, 301, 300);
  endtask

  // Min above max, a clear in the middle of a triple, one and two faulty channels.
  task automatic test_limits_and_clear();
    write_limits(4095, 0, 4095);
    repeat (3) send_round(1000, 2000, 3000, 4000);
    send_round(5, 6, 7, 8);
    send_request(KIND_CLEAR, random_round());
    send_round(5, 6, 7, 8);
    send_round(5, 6, 7, 8);
    write_limits(2000, 2000, 0);
    repeat (3) send_round(2000, 2000, 2000, 2001);
    repeat (3) send_round(1999, 2000, 2000, 2001);
  endtask

  // Random traffic under a handful of limit settings, extremes among them.
  task automatic test_random_traffic(input int unsigned send_pct, input int unsigned recv_pct);
    int lo;
    int hi;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int chunk = 0; chunk < 4; chunk++) begin
      lo = $urandom_range(4095);
      hi = $urandom_range(4095);
      case ((chunk == 0) ? 0 : (chunk == 1) ? 1 : $urandom_range(3))
        0:       write_limits(0, 4095, 0);
        1:       write_limits(4095, 0, 4095);
        2:       write_limits((lo < hi) ? lo : hi, (lo < hi) ? hi : lo, $urandom_range(4095));
        default: write_limits(lo, hi, $urandom_range(4095));
      endcase
      for (int i = 0; i < RANDOM_ITEMS / 4; i++) begin
        if ($urandom_range(99) < 4) send_request(KIND_CLEAR, random_round());
        else                        send_request(KIND_ROUND, random_round());
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_median_and_direction();
    test_truncation();
    test_limits_and_clear();
    test_random_traffic(16, 76);
    test_random_traffic(76, 16);
    test_random_traffic(0, 0);

    wait_until_idle();
    if (mismatch_count == 0 && pending_readings.size() == 0) begin
      $display("quad_light_sensor_sun_error_top regression: pass");
    end else begin
      $display("quad_light_sensor_sun_error_top regression: fail");
    end
    $finish;
  end

endmodule
